// ===== rtl/ckh_pkg.sv =====
// ----------------------------------------------------------------------------
// ckh_pkg: shared types and constants for the three-way cuckoo hash table
// Hash coefficients, table geometry, status and function codes, and the
// command/status records between the controller and the datapath.
// ----------------------------------------------------------------------------
package ckh_pkg;

  localparam int TableSize    = 1024;
  localparam int AddrW        = $clog2(TableSize);
  localparam int KicksPerHash = 17;
  localparam int KickW        = $clog2(KicksPerHash + 1);

  // func codes
  localparam logic [1:0] FuncInsert = 2'd0;
  localparam logic [1:0] FuncRemove = 2'd1;

  // status codes
  localparam logic [2:0] StUpdated  = 3'd0;
  localparam logic [2:0] StInserted = 3'd1;
  localparam logic [2:0] StRemoved  = 3'd2;
  localparam logic [2:0] StFound    = 3'd3;
  localparam logic [2:0] StNotFound = 3'd4;
  localparam logic [2:0] StFull     = 3'd5;
  localparam logic [2:0] StZeroKey  = 3'd6;

  // hash coefficients A, B, C and prime, one row per hash
  localparam logic [31:0] CoefA [3] = '{32'd58193,   32'd711929,  32'd459257};
  localparam logic [31:0] CoefB [3] = '{32'd1258207, 32'd1810057, 32'd808481};
  localparam logic [31:0] CoefC [3] = '{32'd2808193, 32'd9767,    32'd2958259};
  localparam logic [31:0] Prime [3] = '{32'd308383,  32'd608459,  32'd1358333};
  // floor(2^32 / prime), for the reciprocal remainder
  localparam logic [31:0] Recip [3] = '{32'd13927,   32'd7058,    32'd3161};

  // datapath commands
  typedef struct packed {
    logic       load_in;    // capture the input word
    logic       hash_start; // start hashing the working key
    logic [1:0] hash_sel;   // which hash
    logic       hash_in;    // hash operand: 0 input key, 1 key in hand
    logic       rd;         // read both stores at the hashed slot
    logic       wr_key;     // write key store
    logic       wr_val;     // write value store
    logic [1:0] wr_src;     // 0 input key/value, 1 key/value in hand, 2 clear key
    logic       swap;       // key in hand <= resident entry; hash the resident
    logic       clr;        // address the stores from the clearing sweep
    logic       set_res;    // load result
    logic [2:0] res_status;
    logic       res_val;    // value_out from read data
    logic       res_home;   // homeless from the evicted resident
  } ckh_cmd_t;

  typedef struct packed {
    logic hash_done;
    logic key_zero;
    logic hit;    // read key equals input key
    logic empty;  // read key is zero
  } ckh_sts_t;

  localparam logic [1:0] SrcIn    = 2'd0;
  localparam logic [1:0] SrcHand  = 2'd1;
  localparam logic [1:0] SrcClear = 2'd2;

endpackage

// ===== rtl/ckh_ram.sv =====
// ----------------------------------------------------------------------------
// ckh_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module ckh_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== rtl/ckh_hash.sv =====
// ----------------------------------------------------------------------------
// ckh_hash: multi-cycle hash unit
// (A + B*y + C*y*y) mod 2^32, then mod prime by reciprocal multiplication
// with one correction step, then mod table size by mask.
// ----------------------------------------------------------------------------
module ckh_hash (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [1:0]               sel_i,
  input  logic [31:0]              key_i,
  output logic                     done_o,
  output logic [ckh_pkg::AddrW-1:0] slot_o
);
  import ckh_pkg::*;

  typedef enum logic [6:0] {
    HIdle = 7'b0000001, HM1 = 7'b0000010, HM2 = 7'b0000100, HSum = 7'b0001000,
    HR1   = 7'b0010000, HR2 = 7'b0100000, HR3 = 7'b1000000
  } hstate_e;

  hstate_e     state_q, state_d;
  logic [1:0]  sel_q;
  logic [31:0] y_q, by_q, cy_q, s_q, q_q, qp_q;
  logic [63:0] prod;
  logic [31:0] rem, rem_fix;

  // quotient estimate is exact or one low; one subtract corrects it
  always_comb begin
    prod    = {32'd0, s_q} * {32'd0, Recip[sel_q]};
    rem     = s_q - qp_q;
    rem_fix = (rem >= Prime[sel_q]) ? rem - Prime[sel_q] : rem;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      HIdle:   if (start_i) state_d = HM1;
      HM1:     state_d = HM2;
      HM2:     state_d = HSum;
      HSum:    state_d = HR1;
      HR1:     state_d = HR2;
      HR2:     state_d = HR3;
      HR3:     state_d = HIdle;
      default: state_d = HIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= HIdle;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o  <= (state_q == HR3);
    end
  end

  // datapath: B*y and C*y in HM1, C*y*y in HM2, sum in HSum, remainder in HR1-HR3
  always_ff @(posedge clk_i) begin
    case (state_q)
      HIdle: if (start_i) begin
        sel_q <= sel_i;
        y_q   <= key_i[31] ? 32'd0 - key_i : key_i;
      end
      HM1: begin
        by_q <= CoefB[sel_q] * y_q;
        cy_q <= CoefC[sel_q] * y_q;
      end
      HM2:  cy_q <= cy_q * y_q;
      HSum: s_q <= CoefA[sel_q] + by_q + cy_q;
      HR1:  q_q <= prod[63:32];
      HR2:  qp_q <= q_q * Prime[sel_q];
      HR3:  slot_o <= rem_fix[AddrW-1:0];
      default: ;
    endcase
  end
endmodule

// ===== rtl/ckh_datapath.sv =====
// ----------------------------------------------------------------------------
// ckh_datapath: stores, hash unit, entry in hand and result register
// Executes the controller's commands on the key and value stores.
// ----------------------------------------------------------------------------
module ckh_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ckh_pkg::ckh_cmd_t         cmd_i,
  output ckh_pkg::ckh_sts_t         sts_o,
  input  logic [ckh_pkg::AddrW-1:0] clr_addr_i,
  input  logic [65:0]               in_word_i,
  output logic [98:0]               res_o
);
  import ckh_pkg::*;

  logic [31:0] key_q, val_q, hk_q, hv_q;
  logic [31:0] rkey, rval, wkey, wval;
  logic [31:0] hash_key;
  logic [AddrW-1:0] slot, addr_q, ram_addr;
  logic        hash_done;
  logic [2:0]  st_q;
  logic [31:0] vo_q, ho_k_q, ho_v_q;

  // on a kick the evicted resident is hashed straight from read data
  assign hash_key = cmd_i.swap ? rkey : (cmd_i.hash_in ? hk_q : key_q);

  ckh_hash u_hash (
    .clk_i, .rst_ni,
    .start_i(cmd_i.hash_start),
    .sel_i  (cmd_i.hash_sel),
    .key_i  (hash_key),
    .done_o (hash_done),
    .slot_o (slot)
  );

  // hold address from read through write
  always_ff @(posedge clk_i) if (cmd_i.rd) addr_q <= slot;

  assign ram_addr = cmd_i.clr ? clr_addr_i : (cmd_i.rd ? slot : addr_q);

  always_comb begin
    case (cmd_i.wr_src)
      SrcIn:   begin wkey = key_q; wval = val_q; end
      SrcHand: begin wkey = hk_q;  wval = hv_q;  end
      default: begin wkey = '0;    wval = val_q; end
    endcase
  end

  ckh_ram #(.Width(32), .Depth(TableSize)) u_keys (
    .clk_i, .we_i(cmd_i.wr_key), .addr_i(ram_addr),
    .wdata_i(wkey), .rdata_o(rkey));
  ckh_ram #(.Width(32), .Depth(TableSize)) u_vals (
    .clk_i, .we_i(cmd_i.wr_val), .addr_i(ram_addr),
    .wdata_i(wval), .rdata_o(rval));

  assign sts_o = {hash_done, (key_q == '0), (rkey == key_q), (rkey == '0)};

  // input capture and entry in hand
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      key_q <= in_word_i[33:2];
      val_q <= in_word_i[65:34];
      hk_q  <= in_word_i[33:2];
      hv_q  <= in_word_i[65:34];
    end else if (cmd_i.swap) begin
      hk_q <= rkey;
      hv_q <= rval;
    end
    if (cmd_i.set_res) begin
      st_q   <= cmd_i.res_status;
      vo_q   <= cmd_i.res_val ? rval : '0;
      ho_k_q <= cmd_i.res_home ? rkey : '0;
      ho_v_q <= cmd_i.res_home ? rval : '0;
    end
  end

  assign res_o = {ho_v_q, ho_k_q, vo_q, st_q};
endmodule

// ===== rtl/ckh_ctrl.sv =====
// ----------------------------------------------------------------------------
// ckh_ctrl: operation sequencer
// Probes up to three slots, then runs the kick chain for inserts that miss.
// ----------------------------------------------------------------------------
module ckh_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        func_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ckh_pkg::ckh_cmd_t cmd_o,
  input  ckh_pkg::ckh_sts_t sts_i
);
  import ckh_pkg::*;

  typedef enum logic [7:0] {
    SIdle  = 8'b00000001, SCheck = 8'b00000010, SProbe = 8'b00000100,
    SRead  = 8'b00001000, SEval  = 8'b00010000, SKHash = 8'b00100000,
    SKRead = 8'b01000000, SKEval = 8'b10000000
  } state_e;

  state_e      state_q, state_d;
  logic [1:0]  func_q, func_d, h_q, h_d;
  logic [KickW-1:0] k_q, k_d;
  logic        ov_q, ov_d;

  assign in_ready_o  = (state_q == SIdle) && !ov_q;
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q; func_d = func_q; h_d = h_q; k_d = k_q;
    ov_d    = ov_q && !out_ready_i;
    cmd_o   = '0;
    cmd_o.hash_sel = h_q;
    case (state_q)
      SIdle: if (in_valid_i && in_ready_o) begin
        cmd_o.load_in = 1'b1;
        func_d = func_i; h_d = 2'd0; state_d = SCheck;
      end
      SCheck: begin
        if (sts_i.key_zero) begin
          cmd_o.set_res = 1'b1; cmd_o.res_status = StZeroKey;
          ov_d = 1'b1; state_d = SIdle;
        end else begin
          cmd_o.hash_start = 1'b1; state_d = SProbe;
        end
      end
      SProbe: if (sts_i.hash_done) begin
        cmd_o.rd = 1'b1; state_d = SRead;
      end
      SRead: state_d = SEval;
      SEval: begin
        if (sts_i.hit) begin
          cmd_o.set_res = 1'b1; ov_d = 1'b1; state_d = SIdle;
          case (func_q)
            FuncInsert: begin
              cmd_o.wr_val = 1'b1; cmd_o.wr_src = SrcIn; cmd_o.res_status = StUpdated;
            end
            FuncRemove: begin
              cmd_o.wr_key = 1'b1; cmd_o.wr_src = SrcClear; cmd_o.res_status = StRemoved;
            end
            default: begin
              cmd_o.res_status = StFound; cmd_o.res_val = 1'b1;
            end
          endcase
        end else if (h_q != 2'd2) begin
          h_d = h_q + 2'd1; cmd_o.hash_sel = h_d;
          cmd_o.hash_start = 1'b1; state_d = SProbe;
        end else if (func_q == FuncInsert) begin
          h_d = 2'd0; k_d = '0; cmd_o.hash_sel = 2'd0;
          cmd_o.hash_start = 1'b1; state_d = SKHash;
        end else begin
          cmd_o.set_res = 1'b1; cmd_o.res_status = StNotFound;
          ov_d = 1'b1; state_d = SIdle;
        end
      end
      SKHash: begin
        cmd_o.hash_in = 1'b1;
        if (sts_i.hash_done) begin
          cmd_o.rd = 1'b1; state_d = SKRead;
        end
      end
      SKRead: state_d = SKEval;
      SKEval: begin
        // write hand into slot; resident becomes hand
        cmd_o.wr_key = 1'b1; cmd_o.wr_val = 1'b1; cmd_o.wr_src = SrcHand;
        if (sts_i.empty) begin
          cmd_o.set_res = 1'b1; cmd_o.res_status = StInserted;
          ov_d = 1'b1; state_d = SIdle;
        end else if (k_q == KickW'(KicksPerHash - 1) && h_q == 2'd2) begin
          // kick chain exhausted: the evicted resident is homeless
          cmd_o.set_res = 1'b1; cmd_o.res_status = StFull; cmd_o.res_home = 1'b1;
          ov_d = 1'b1; state_d = SIdle;
        end else begin
          // rehash the resident with the hash of the current group
          cmd_o.swap = 1'b1; cmd_o.hash_start = 1'b1; cmd_o.hash_sel = h_q;
          state_d = SKHash;
          if (k_q == KickW'(KicksPerHash - 1)) begin
            k_d = '0;
            h_d = h_q + 2'd1;
          end else begin
            k_d = k_q + KickW'(1);
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; func_q <= '0; h_q <= '0; k_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; func_q <= func_d; h_q <= h_d; k_q <= k_d; ov_q <= ov_d;
    end
  end
endmodule

// ===== rtl/three_way_cuckoo_hash_table_unit.sv =====
// ----------------------------------------------------------------------------
// three_way_cuckoo_hash_table_unit: three-way cuckoo hash table, 1024 slots
// Lookup, remove and insert with bounded kick chain; reports full.
// ----------------------------------------------------------------------------
// A hash runs two multiply stages, a sum and a three-step reciprocal
// remainder; a probe hashes, reads the slot and compares. Probes stop at a
// hit; a zero key is answered without a probe. An insert that misses in all
// three slots makes placement attempts, at most 51, before it reports full.
// One word at a time; the next word is taken the cycle after the result is.
// Reset clears control state; a sweep then empties all 1024 key slots.
module three_way_cuckoo_hash_table_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,  // func[1:0], key[33:2], value[65:34], zero pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata   // status[2:0], value_out[34:3],
                                      // homeless_key[66:35], homeless_value[98:67],
                                      // zero pad
);
  import ckh_pkg::*;

  ckh_cmd_t cmd, cmd_ctl;
  ckh_sts_t sts;
  logic [AddrW:0] clr_q;
  logic clr_busy, rdy;
  logic [98:0] res;

  // clearing sweep of the key store after reset
  assign clr_busy = !clr_q[AddrW];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (clr_busy) clr_q <= clr_q + 1'b1;
  end

  ckh_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid && !clr_busy),
    .in_ready_o (rdy),
    .func_i     (s_axis_tdata[1:0]),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd_ctl),
    .sts_i      (sts)
  );
  assign s_axis_tready = rdy && !clr_busy;

  always_comb begin
    cmd = cmd_ctl;
    if (clr_busy) begin
      cmd = '0;
      cmd.clr    = 1'b1;
      cmd.wr_key = 1'b1;
      cmd.wr_src = SrcClear;
    end
  end

  ckh_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i     (cmd),
    .sts_o     (sts),
    .clr_addr_i(clr_q[AddrW-1:0]),
    .in_word_i (s_axis_tdata[65:0]),
    .res_o     (res)
  );

  assign m_axis_tdata = {5'd0, res};
endmodule

// ===== tb/tb_three_way_cuckoo_hash_table_unit.sv =====
// ----------------------------------------------------------------------------
// tb_three_way_cuckoo_hash_table_unit: stream-level test of the cuckoo table
// A directed sequence covers the zero key, the extreme keys, every function
// code, updates and removals. Random traffic, mostly from a bounded key pool,
// follows under several idle and stall mixes and one long output hold-off.
// A local predictor tracks the table and checks each result word against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_three_way_cuckoo_hash_table_unit;
  import ckh_pkg::*;

  localparam logic [1:0] FuncLookup = 2'd2;
  localparam logic [1:0] FuncAlias  = 2'd3;  // unused code, acts as lookup
  localparam int PoolSize = 400;

  typedef struct packed {
    logic [2:0]         status;
    logic [31:0]        value_out;
    logic signed [31:0] homeless_key;
    logic [31:0]        homeless_value;
  } table_reply_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata = '0;  // func[1:0], key[33:2], value[65:34], zero pad
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;       // status, value_out, homeless_key, homeless_value

  three_way_cuckoo_hash_table_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // shadow table and pending replies
  logic [31:0]  shadow_key [TableSize];
  logic [31:0]  shadow_val [TableSize];
  table_reply_t pending_replies [$];
  logic [31:0]  key_pool [PoolSize];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;
  int error_count = 0;
  int words_sent = 0;
  int replies_seen = 0;
  int status_seen [8];

  // slot of a key under one of the three hashes
  function automatic logic [31:0] slot_for(input int sel, input logic [31:0] key);
    logic [31:0] y;
    logic [31:0] s;
    y = key[31] ? (32'd0 - key) : key;
    s = CoefA[sel] + CoefB[sel] * y + (CoefC[sel] * y) * y;
    return (s % Prime[sel]) % TableSize;
  endfunction

  // apply one word to the shadow table, return the reply it must give
  function automatic table_reply_t table_apply(input logic [1:0] func,
                                               input logic [31:0] key,
                                               input logic [31:0] value);
    table_reply_t r;
    logic [31:0] hk, hv, tk, tv, a, s;
    bit done;
    r = '0;
    r.status = StNotFound;
    done = 1'b0;
    if (key == 32'd0) begin
      r.status = StZeroKey;
    end else if (func == FuncInsert) begin
      for (int h = 0; h < 3 && !done; h++) begin
        s = slot_for(h, key);
        if (shadow_key[s] == key) begin
          shadow_val[s] = value;
          r.status = StUpdated;
          done = 1'b1;
        end
      end
      hk = key;
      hv = value;
      a = slot_for(0, key);
      for (int h = 0; h < 3 && !done; h++) begin
        for (int i = 0; i < KicksPerHash && !done; i++) begin
          if (shadow_key[a] == 32'd0) begin
            shadow_key[a] = hk;
            shadow_val[a] = hv;
            r.status = StInserted;
            done = 1'b1;
          end else begin
            tk = shadow_key[a];
            tv = shadow_val[a];
            shadow_key[a] = hk;
            shadow_val[a] = hv;
            hk = tk;
            hv = tv;
            a = slot_for(h, hk);
          end
        end
      end
      if (!done) begin
        r.status = StFull;
        r.homeless_key = hk;
        r.homeless_value = hv;
      end
    end else begin
      for (int h = 0; h < 3 && !done; h++) begin
        s = slot_for(h, key);
        if (shadow_key[s] == key) begin
          done = 1'b1;
          if (func == FuncRemove) begin
            shadow_key[s] = 32'd0;
            r.status = StRemoved;
          end else begin
            r.status = StFound;
            r.value_out = shadow_val[s];
          end
        end
      end
    end
    return r;
  endfunction

  // drive one word, wait for acceptance, record its expected reply
  task automatic send_word(input logic [1:0] func, input logic [31:0] key,
                           input logic [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {6'd0, value, key, func};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_replies.push_back(table_apply(func, key, value));
    words_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_key();
    int sel;
    sel = $urandom_range(99);
    if (sel < 85) return key_pool[$urandom_range(PoolSize - 1)];
    if (sel < 87) return 32'd0;
    if (sel < 89) return 32'h8000_0000;
    return $urandom;
  endfunction

  function automatic logic [1:0] pick_func();
    int sel;
    sel = $urandom_range(99);
    if (sel < 50) return FuncInsert;
    if (sel < 70) return FuncRemove;
    if (sel < 95) return FuncLookup;
    return FuncAlias;
  endfunction

  task automatic test_directed();
    send_word(FuncInsert, 32'd0, 32'hFFFF_FFFF);
    send_word(FuncRemove, 32'd0, 32'd0);
    send_word(FuncLookup, 32'd0, 32'd0);
    send_word(FuncAlias,  32'd0, 32'd0);
    send_word(FuncLookup, 32'h8000_0000, 32'd0);
    send_word(FuncInsert, 32'h8000_0000, 32'hA5A5_5A5A);
    send_word(FuncInsert, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_word(FuncInsert, 32'hFFFF_FFFF, 32'd0);
    send_word(FuncInsert, 32'd1, 32'h1234_5678);
    send_word(FuncInsert, 32'd1, 32'hDEAD_BEEF);
    send_word(FuncLookup, 32'd1, 32'd0);
    send_word(FuncAlias,  32'h8000_0000, 32'd0);
    send_word(FuncLookup, 32'h7FFF_FFFF, 32'd0);
    send_word(FuncLookup, 32'hFFFF_FFFF, 32'd0);
    send_word(FuncRemove, 32'h7FFF_FFFF, 32'd0);
    send_word(FuncLookup, 32'h7FFF_FFFF, 32'd0);
    send_word(FuncRemove, 32'h7FFF_FFFF, 32'd0);
    send_word(FuncRemove, 32'h8000_0000, 32'd0);
    send_word(FuncInsert, 32'h8000_0000, 32'h0000_0001);
    send_word(FuncAlias,  32'h8000_0000, 32'd0);
  endtask

  task automatic test_random(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_word(pick_func(), pick_key(), $urandom);
  endtask

  // output held off for a long stretch while words keep coming
  task automatic test_output_holdoff();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 600;
    repeat (8) send_word(pick_func(), pick_key(), $urandom);
  endtask

  // output ready: random stalls, plus the counted hold-off
  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // reply checker
  always @(posedge clk_i) begin
    table_reply_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = table_reply_t'({m_axis_tdata[98:67], m_axis_tdata[66:35],
                            m_axis_tdata[34:3], m_axis_tdata[2:0]});
      got.status         = m_axis_tdata[2:0];
      got.value_out      = m_axis_tdata[34:3];
      got.homeless_key   = m_axis_tdata[66:35];
      got.homeless_value = m_axis_tdata[98:67];
      replies_seen++;
      status_seen[got.status]++;
      if (pending_replies.size() == 0) begin
        $error("reply word with none pending: status %0d", got.status);
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          error_count++;
        end
        if (got.value_out !== want.value_out) begin
          $error("value_out: expected %h, got %h", want.value_out, got.value_out);
          error_count++;
        end
        if (got.homeless_key !== want.homeless_key) begin
          $error("homeless_key: expected %h, got %h", want.homeless_key,
                 got.homeless_key);
          error_count++;
        end
        if (got.homeless_value !== want.homeless_value) begin
          $error("homeless_value: expected %h, got %h", want.homeless_value,
                 got.homeless_value);
          error_count++;
        end
      end
    end
  end

  initial begin
    int guard;
    for (int i = 0; i < TableSize; i++) begin
      shadow_key[i] = '0;
      shadow_val[i] = '0;
    end
    for (int i = 0; i < PoolSize; i++) begin
      key_pool[i] = $urandom;
      if (key_pool[i] == 32'd0) key_pool[i] = 32'd7;
    end
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random(500, 0, 0);
    test_random(500, 77, 0);
    test_random(500, 0, 77);
    test_output_holdoff();
    test_random(500, 30, 30);
    s_axis_tvalid = 1'b0;
    recv_stall_pct = 0;

    // drain, then let the block settle
    guard = 0;
    while (pending_replies.size() != 0 && guard < 500000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (300) @(negedge clk_i);

    $display("covered %0d words, %0d replies: inserted %0d, updated %0d, full %0d,",
             words_sent, replies_seen, status_seen[StInserted], status_seen[StUpdated],
             status_seen[StFull]);
    $display("  removed %0d, found %0d, not found %0d, zero key %0d",
             status_seen[StRemoved], status_seen[StFound], status_seen[StNotFound],
             status_seen[StZeroKey]);
    if (error_count == 0 && pending_replies.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #400ms;
    $display("status: fail");
    $finish;
  end

endmodule
